@@ rtl/b32d_pkg.sv @@
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and helpers of the base32 stream decoder.
// ----------------------------------------------------------------------------
package b32d_pkg;

  // input beat opcodes
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  // group geometry
  localparam int GROUP_LEN   = 8;
  localparam int SYM_BITS    = 5;
  localparam int GROUP_BITS  = GROUP_LEN * SYM_BITS;
  localparam int FILL_W      = $clog2(GROUP_LEN);
  localparam int VCHARS_W    = $clog2(GROUP_LEN + 1);
  localparam int MAX_BYTES   = GROUP_BITS / 8;
  localparam int BCOUNT_W    = $clog2(MAX_BYTES + 1);
  localparam int SHAMT_W     = $clog2(GROUP_BITS + 1);

  // character codes
  localparam logic [7:0] CH_PAD   = 8'h3D;  // '='
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_DIGIT_2 = 8'h32;
  localparam logic [7:0] CH_DIGIT_7 = 8'h37;
  localparam logic [7:0] DIGIT_OFS  = 8'd24;  // '2' maps to 26

  // default depth of the group queue
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       error;
    logic       last_in_run;
  } out_item_t;

  // one flushed group as handed from front to back
  typedef struct packed {
    logic                  err;
    logic [BCOUNT_W-1:0]   count;
    logic [GROUP_BITS-1:0] bits;
  } grp_rec_t;

  // build the record of a flushed group
  function automatic grp_rec_t make_rec(input logic bad,
                                        input logic [VCHARS_W-1:0] vchars,
                                        input logic [GROUP_BITS-1:0] bits);
    grp_rec_t rec;
    logic [SHAMT_W-1:0] nbits;
    nbits = SHAMT_W'(vchars) * SHAMT_W'(SYM_BITS);
    if (bad) begin
      rec.err   = 1'b1;
      rec.count = BCOUNT_W'(1);
      rec.bits  = '0;
    end else begin
      rec.err   = 1'b0;
      rec.count = BCOUNT_W'(nbits >> 3);
      rec.bits  = bits;
    end
    return rec;
  endfunction

endpackage

@@ rtl/b32d_front.sv @@
// ----------------------------------------------------------------------------
// b32d_front
// Accepts character beats, decodes symbols and gathers groups of eight;
// pushes one record per flushed group that yields any result.
// ----------------------------------------------------------------------------
module b32d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  b32d_pkg::in_item_t  item,
  output logic                push,
  output b32d_pkg::grp_rec_t  push_rec,
  input  logic                q_full
);

  logic [b32d_pkg::GROUP_BITS-1:0] group_bits, group_bits_next;
  logic [b32d_pkg::FILL_W-1:0]     group_fill, group_fill_next;
  logic [b32d_pkg::VCHARS_W-1:0]   value_chars, value_chars_next;
  logic                            pad_seen, pad_seen_next;
  logic                            bad_char_seen, bad_char_seen_next;
  logic                            discarding, discarding_next;

  logic                            accept;
  logic [7:0]                      ch;
  logic                            is_ws;
  logic                            sym_ok;
  logic [b32d_pkg::SYM_BITS-1:0]   sym_val;
  logic [b32d_pkg::SHAMT_W-1:0]    shamt;
  logic [b32d_pkg::GROUP_BITS-1:0] upd_bits;
  logic [b32d_pkg::VCHARS_W-1:0]   upd_vc;
  logic                            upd_pad;
  logic                            upd_bad;
  b32d_pkg::grp_rec_t              rec;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign ch         = item.char_code;

  // character classification
  always_comb begin
    is_ws = (ch == b32d_pkg::CH_SPACE) || (ch == b32d_pkg::CH_TAB) ||
            (ch == b32d_pkg::CH_CR) || (ch == b32d_pkg::CH_LF);
    sym_ok  = 1'b0;
    sym_val = '0;
    if (ch >= b32d_pkg::CH_UPPER_A && ch <= b32d_pkg::CH_UPPER_Z) begin
      sym_ok  = 1'b1;
      sym_val = b32d_pkg::SYM_BITS'(ch - b32d_pkg::CH_UPPER_A);
    end else if (ch >= b32d_pkg::CH_DIGIT_2 && ch <= b32d_pkg::CH_DIGIT_7) begin
      sym_ok  = 1'b1;
      sym_val = b32d_pkg::SYM_BITS'(ch - b32d_pkg::DIGIT_OFS);
    end
  end

  // group state after this character
  always_comb begin
    shamt    = b32d_pkg::SHAMT_W'(value_chars) * b32d_pkg::SHAMT_W'(b32d_pkg::SYM_BITS);
    upd_bits = group_bits;
    upd_vc   = value_chars;
    upd_pad  = pad_seen;
    upd_bad  = bad_char_seen;
    if (!pad_seen && !bad_char_seen) begin
      if (ch == b32d_pkg::CH_PAD) begin
        upd_pad = 1'b1;
      end else if (!sym_ok) begin
        upd_bad = 1'b1;
      end else begin
        upd_bits = group_bits |
                   ({sym_val, {(b32d_pkg::GROUP_BITS-b32d_pkg::SYM_BITS){1'b0}}} >> shamt);
        upd_vc   = value_chars + b32d_pkg::VCHARS_W'(1);
      end
    end
  end

  // next state and queue push
  always_comb begin
    group_bits_next    = group_bits;
    group_fill_next    = group_fill;
    value_chars_next   = value_chars;
    pad_seen_next      = pad_seen;
    bad_char_seen_next = bad_char_seen;
    discarding_next    = discarding;
    push               = 1'b0;
    rec                = b32d_pkg::make_rec(bad_char_seen, value_chars, group_bits);
    if (accept) begin
      if (item.op == b32d_pkg::OP_EOS) begin
        // flush partial group and start a new stream
        if (!discarding && group_fill != '0)
          push = rec.err || (rec.count != '0);
        group_bits_next    = '0;
        group_fill_next    = '0;
        value_chars_next   = '0;
        pad_seen_next      = 1'b0;
        bad_char_seen_next = 1'b0;
        discarding_next    = 1'b0;
      end else if (!discarding && !is_ws) begin
        if (group_fill == b32d_pkg::FILL_W'(b32d_pkg::GROUP_LEN - 1)) begin
          // group complete
          rec  = b32d_pkg::make_rec(upd_bad, upd_vc, upd_bits);
          push = rec.err || (rec.count != '0);
          group_bits_next    = '0;
          group_fill_next    = '0;
          value_chars_next   = '0;
          pad_seen_next      = 1'b0;
          bad_char_seen_next = 1'b0;
          if (upd_bad)
            discarding_next = 1'b1;
        end else begin
          group_bits_next    = upd_bits;
          group_fill_next    = group_fill + b32d_pkg::FILL_W'(1);
          value_chars_next   = upd_vc;
          pad_seen_next      = upd_pad;
          bad_char_seen_next = upd_bad;
        end
      end
    end
  end

  assign push_rec = rec;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits    <= '0;
      group_fill    <= '0;
      value_chars   <= '0;
      pad_seen      <= 1'b0;
      bad_char_seen <= 1'b0;
      discarding    <= 1'b0;
    end else begin
      group_bits    <= group_bits_next;
      group_fill    <= group_fill_next;
      value_chars   <= value_chars_next;
      pad_seen      <= pad_seen_next;
      bad_char_seen <= bad_char_seen_next;
      discarding    <= discarding_next;
    end
  end

endmodule

@@ rtl/b32d_queue.sv @@
// ----------------------------------------------------------------------------
// b32d_queue
// Small register queue of group records between front and back.
// ----------------------------------------------------------------------------
module b32d_queue #(
  parameter int DEPTH = b32d_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  b32d_pkg::grp_rec_t push_rec,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output b32d_pkg::grp_rec_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  b32d_pkg::grp_rec_t entries [DEPTH];
  logic [AW-1:0]      wr_ptr;
  logic [AW-1:0]      rd_ptr;
  logic [CW-1:0]      fill;
  logic               do_push;
  logic               do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push)
      entries[wr_ptr] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push)
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (do_pop)
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      if (do_push && !do_pop)
        fill <= fill + CW'(1);
      else if (do_pop && !do_push)
        fill <= fill - CW'(1);
    end
  end

endmodule

@@ rtl/b32d_back.sv @@
// ----------------------------------------------------------------------------
// b32d_back
// Takes group records from the queue and sends their bytes, one beat per
// cycle while result_stall is low, on the result channel.
// ----------------------------------------------------------------------------
module b32d_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_not_empty,
  input  b32d_pkg::grp_rec_t  q_head,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output b32d_pkg::out_item_t result
);

  logic                            busy;
  logic                            err;
  logic [b32d_pkg::BCOUNT_W-1:0]   remaining;
  logic [b32d_pkg::GROUP_BITS-1:0] bits;
  logic                            taken;
  logic                            last_beat;

  assign result_valid       = busy;
  assign last_beat          = (remaining == b32d_pkg::BCOUNT_W'(1));
  assign result.data_byte   = bits[b32d_pkg::GROUP_BITS-1 -: 8];
  assign result.error       = err;
  assign result.last_in_run = last_beat;

  assign taken = busy && !result_stall;
  assign pop   = q_not_empty && (!busy || (taken && last_beat));

  // control: busy flag and byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      remaining <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      remaining <= q_head.count;
    end else if (taken) begin
      if (last_beat)
        busy <= 1'b0;
      remaining <= remaining - b32d_pkg::BCOUNT_W'(1);
    end
  end

  // payload: shift out one byte per beat
  always_ff @(posedge clk) begin
    if (pop) begin
      bits <= q_head.bits;
      err  <= q_head.err;
    end else if (taken) begin
      bits <= bits << 8;
    end
  end

endmodule

@@ rtl/base32_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// base32_stream_decoder
// The first byte of a group is registered in the group queue and then in the
// back end after the beat that completes or flushes the group. Throughput: one
// input beat per cycle; input stalls only when the group queue between front
// and back is full. Output runs at one byte per cycle while not stalled.
// Reset (rst, synchronous): clears group state, discard flag, queue, output.
// ----------------------------------------------------------------------------
module base32_stream_decoder #(
  parameter int QUEUE_DEPTH = b32d_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  b32d_pkg::in_item_t  item,
  output logic                result_valid,
  input  logic                result_stall,
  output b32d_pkg::out_item_t result
);

  logic               push;
  b32d_pkg::grp_rec_t push_rec;
  logic               q_full;
  logic               q_not_empty;
  logic               pop;
  b32d_pkg::grp_rec_t q_head;

  // character intake and grouping
  b32d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_rec   (push_rec),
    .q_full     (q_full)
  );

  // group record queue
  b32d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // byte output
  b32d_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_not_empty  (q_not_empty),
    .q_head       (q_head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
